// ===== hdl/tcgp_pkg.sv =====
`default_nettype none
package tcgp_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int ROW_BITS    = 6;
   localparam int MAX_SPAN    = 20;
   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_BITS   = 4;
   localparam int COORD_BITS  = 16;

   localparam logic [3:0] TOK_HDR_OPEN   = 4'd0;
   localparam logic [3:0] TOK_HDR_CLOSE  = 4'd1;
   localparam logic [3:0] TOK_ROW        = 4'd2;
   localparam logic [3:0] TOK_EMPTY_CELL = 4'd3;
   localparam logic [3:0] TOK_CELL_OPEN  = 4'd4;
   localparam logic [3:0] TOK_COLSPAN    = 4'd5;
   localparam logic [3:0] TOK_ROWSPAN    = 4'd6;
   localparam logic [3:0] TOK_CELL_CLOSE = 4'd7;
   localparam logic [3:0] TOK_IGNORE     = 4'd8;
   localparam logic [3:0] TOK_END        = 4'd9;

   localparam logic RES_CELL    = 1'b0;
   localparam logic RES_SUMMARY = 1'b1;

   localparam logic [15:0] DEBT_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_MREAD,
      ST_MWRITE,
      ST_EMIT,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] left;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] right;
      logic [COORD_BITS-1:0] bottom;
   } box_type;

   // ones at bit positions n and above; zero when n reaches the row width
   function automatic logic [MAX_COLS-1:0] ones_from(input logic [6:0] n);
      logic [MAX_COLS-1:0] m;
      begin
         m = '0;
         if (n < 7'(MAX_COLS))
            m = {MAX_COLS{1'b1}} << n;
         return m;
      end
   endfunction

   function automatic logic [4:0] clamp_span(input logic [7:0] v);
      logic [4:0] s;
      begin
         if (v == 8'd0)
            s = 5'd1;
         else if (v > 8'(MAX_SPAN))
            s = 5'(MAX_SPAN);
         else
            s = v[4:0];
         return s;
      end
   endfunction

endpackage
`default_nettype wire

// ===== hdl/table_cell_grid_placement.sv =====
// Flow: a cell word passes FETCH, SCAN, then a MREAD/MWRITE pair per marked row (rows marked
//   is the row span clipped at the grid edge), then EMIT, which waits for the previous
//   result word to drain; an end word yields its summary from SUM, after the same wait.
// Words: one at a time; the occupancy row read-modify-write loop (a read, then a write, per
//   marked row) sets the cell rate. Other words return to idle without that loop.
// Reset: synchronous, active high; clears control state and all occupancy valid bits at once.
`default_nettype none
module table_cell_grid_placement (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_token_kind,
   input  wire logic [7:0]  req_span_value,
   input  wire logic        req_has_box,
   input  wire logic [15:0] req_box_left,
   input  wire logic [15:0] req_box_top,
   input  wire logic [15:0] req_box_right,
   input  wire logic [15:0] req_box_bottom,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_result_kind,
   output logic [6:0]       rsp_grid_row,
   output logic [6:0]       rsp_grid_col,
   output logic [4:0]       rsp_rows_spanned,
   output logic [4:0]       rsp_cols_spanned,
   output logic             rsp_header_cell,
   output logic             rsp_box_valid,
   output logic [15:0]      rsp_cell_left,
   output logic [15:0]      rsp_cell_top,
   output logic [15:0]      rsp_cell_right,
   output logic [15:0]      rsp_cell_bottom,
   output logic             rsp_grid_overflow
);

   localparam int RB = tcgp_pkg::ROW_BITS;
   localparam int NC = tcgp_pkg::MAX_COLS;
   localparam int QB = tcgp_pkg::QPTR_BITS;

   // control state
   tcgp_pkg::state_type state_ff, state_in;
   logic [RB-1:0] cur_row_ff, cur_row_in;
   logic          row_seen_ff, row_seen_in;
   logic          row_clip_ff, row_clip_in;
   logic          in_cell_ff, in_cell_in;
   logic          in_hdr_ff, in_hdr_in;
   logic [4:0]    pend_cspan_ff, pend_cspan_in;
   logic [4:0]    pend_rspan_ff, pend_rspan_in;
   logic [6:0]    rows_used_ff, rows_used_in;
   logic [6:0]    cols_used_ff, cols_used_in;
   logic [15:0]   debt_ff, debt_in;
   logic [QB:0]   q_cnt_ff, q_cnt_in;
   logic [QB-1:0] q_head_ff, q_head_in;
   logic [QB-1:0] q_tail_ff, q_tail_in;
   logic [NC-1:0] row_vld_ff, row_vld_in;

   // placement in progress
   logic [RB-1:0] pl_row_ff, pl_row_in;
   logic [4:0]    pl_cspan_ff, pl_cspan_in;
   logic [4:0]    pl_rspan_ff, pl_rspan_in;
   logic [6:0]    pl_col_ff, pl_col_in;
   logic [6:0]    pl_rend_ff, pl_rend_in;
   logic [6:0]    pl_cend_ff, pl_cend_in;
   logic          pl_ovf_ff, pl_ovf_in;
   logic [NC-1:0] mask_ff, mask_in;
   logic [RB-1:0] mark_row_ff, mark_row_in;

   // occupancy memory and box queue
   logic [NC-1:0]    occ_mem [tcgp_pkg::MAX_ROWS];
   logic [NC-1:0]    occ_rd_ff;
   logic             rd_vld_ff;
   logic [RB-1:0]    rd_addr;
   logic             occ_we;
   logic [NC-1:0]    occ_wdata;
   tcgp_pkg::box_type box_mem [tcgp_pkg::QUEUE_DEPTH];
   logic             q_we;
   tcgp_pkg::box_type q_wdata;
   tcgp_pkg::box_type q_head_box_ff;

   // result word
   logic          rsp_valid_ff, rsp_valid_in;
   logic          res_kind_ff, res_kind_in;
   logic [6:0]    res_row_ff, res_row_in;
   logic [6:0]    res_col_ff, res_col_in;
   logic [4:0]    res_rspan_ff, res_rspan_in;
   logic [4:0]    res_cspan_ff, res_cspan_in;
   logic          res_hdr_ff, res_hdr_in;
   logic          res_bvld_ff, res_bvld_in;
   tcgp_pkg::box_type res_box_ff, res_box_in;
   logic          res_ovf_ff, res_ovf_in;

   logic          accept;
   logic          is_place;
   logic [NC-1:0] occ_row;
   logic [NC-1:0] span_mask;
   logic [NC-1:0] fit;
   logic [6:0]    fit_col;
   logic [6:0]    rsum, csum, rend, cend;
   logic          out_free;

   assign req_ready = (state_ff == tcgp_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff;
   // a close word only places a cell while one is open
   assign is_place  = (req_token_kind == tcgp_pkg::TOK_EMPTY_CELL) ||
                      ((req_token_kind == tcgp_pkg::TOK_CELL_CLOSE) && in_cell_ff);

   // rows never written read as free
   assign occ_row    = rd_vld_ff ? occ_rd_ff : '0;
   assign rd_addr    = (state_ff == tcgp_pkg::ST_FETCH) ? pl_row_ff : mark_row_ff;

   // first-fit search: a column fits when its span window is free; beyond the edge counts free
   always_comb begin
      span_mask = ~({NC{1'b1}} << pl_cspan_ff);
      fit_col   = 7'(NC);
      for (int c = 0; c < NC; c++)
         fit[c] = (((occ_row >> c) & span_mask) == '0);
      for (int c = NC - 1; c >= 0; c--)
         if (fit[c])
            fit_col = 7'(c);
      rsum = {1'b0, pl_row_ff} + {2'b0, pl_rspan_ff};
      csum = fit_col + {2'b0, pl_cspan_ff};
      rend = (rsum > 7'(tcgp_pkg::MAX_ROWS)) ? 7'(tcgp_pkg::MAX_ROWS) : rsum;
      cend = (csum > 7'(NC)) ? 7'(NC) : csum;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcgp_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_token_kind == tcgp_pkg::TOK_END)
                  state_in = tcgp_pkg::ST_SUM;
               else if (is_place)
                  state_in = tcgp_pkg::ST_FETCH;
            end
         end
         tcgp_pkg::ST_FETCH:  state_in = tcgp_pkg::ST_SCAN;
         tcgp_pkg::ST_SCAN:   state_in = tcgp_pkg::ST_MREAD;
         tcgp_pkg::ST_MREAD:  state_in = tcgp_pkg::ST_MWRITE;
         tcgp_pkg::ST_MWRITE: begin
            if (({1'b0, mark_row_ff} + 7'd1) >= pl_rend_ff)
               state_in = tcgp_pkg::ST_EMIT;
            else
               state_in = tcgp_pkg::ST_MREAD;
         end
         tcgp_pkg::ST_EMIT: if (out_free) state_in = tcgp_pkg::ST_IDLE;
         tcgp_pkg::ST_SUM:  if (out_free) state_in = tcgp_pkg::ST_IDLE;
         default:           state_in = tcgp_pkg::ST_IDLE;
      endcase
   end

   // datapath and bookkeeping
   always_comb begin
      cur_row_in    = cur_row_ff;
      row_seen_in   = row_seen_ff;
      row_clip_in   = row_clip_ff;
      in_cell_in    = in_cell_ff;
      in_hdr_in     = in_hdr_ff;
      pend_cspan_in = pend_cspan_ff;
      pend_rspan_in = pend_rspan_ff;
      rows_used_in  = rows_used_ff;
      cols_used_in  = cols_used_ff;
      debt_in       = debt_ff;
      q_cnt_in      = q_cnt_ff;
      q_head_in     = q_head_ff;
      q_tail_in     = q_tail_ff;
      row_vld_in    = row_vld_ff;
      pl_row_in     = pl_row_ff;
      pl_cspan_in   = pl_cspan_ff;
      pl_rspan_in   = pl_rspan_ff;
      pl_col_in     = pl_col_ff;
      pl_rend_in    = pl_rend_ff;
      pl_cend_in    = pl_cend_ff;
      pl_ovf_in     = pl_ovf_ff;
      mask_in       = mask_ff;
      mark_row_in   = mark_row_ff;
      occ_we        = 1'b0;
      occ_wdata     = occ_row | mask_ff;
      q_we          = 1'b0;
      q_wdata       = {req_box_left, req_box_top, req_box_right, req_box_bottom};
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      res_kind_in   = res_kind_ff;
      res_row_in    = res_row_ff;
      res_col_in    = res_col_ff;
      res_rspan_in  = res_rspan_ff;
      res_cspan_in  = res_cspan_ff;
      res_hdr_in    = res_hdr_ff;
      res_bvld_in   = res_bvld_ff;
      res_box_in    = res_box_ff;
      res_ovf_in    = res_ovf_ff;

      case (state_ff)
         tcgp_pkg::ST_IDLE: begin
            if (accept) begin
               // a carried box first pays off debt, else joins the queue if room
               if (req_has_box) begin
                  if (debt_ff != 16'd0) begin
                     debt_in = debt_ff - 16'd1;
                  end else if (q_cnt_ff < (QB+1)'(tcgp_pkg::QUEUE_DEPTH)) begin
                     q_we      = 1'b1;
                     q_tail_in = q_tail_ff + 1'b1;
                     q_cnt_in  = q_cnt_ff + 1'b1;
                  end
               end
               case (req_token_kind)
                  tcgp_pkg::TOK_HDR_OPEN:  in_hdr_in = 1'b1;
                  tcgp_pkg::TOK_HDR_CLOSE: in_hdr_in = 1'b0;
                  tcgp_pkg::TOK_ROW: begin
                     if (!row_seen_ff) begin
                        row_seen_in = 1'b1;
                        cur_row_in  = '0;
                     end else if (cur_row_ff != RB'(tcgp_pkg::MAX_ROWS - 1)) begin
                        cur_row_in = cur_row_ff + 1'b1;
                     end else begin
                        row_clip_in = 1'b1;
                     end
                  end
                  tcgp_pkg::TOK_EMPTY_CELL: begin
                     row_seen_in = 1'b1;
                     pl_row_in   = cur_row_ff;
                     pl_cspan_in = 5'd1;
                     pl_rspan_in = 5'd1;
                  end
                  tcgp_pkg::TOK_CELL_OPEN: begin
                     in_cell_in    = 1'b1;
                     pend_cspan_in = 5'd1;
                     pend_rspan_in = 5'd1;
                  end
                  tcgp_pkg::TOK_COLSPAN:
                     if (in_cell_ff) pend_cspan_in = tcgp_pkg::clamp_span(req_span_value);
                  tcgp_pkg::TOK_ROWSPAN:
                     if (in_cell_ff) pend_rspan_in = tcgp_pkg::clamp_span(req_span_value);
                  tcgp_pkg::TOK_CELL_CLOSE: begin
                     if (in_cell_ff) begin
                        in_cell_in  = 1'b0;
                        row_seen_in = 1'b1;
                        pl_row_in   = cur_row_ff;
                        pl_cspan_in = pend_cspan_ff;
                        pl_rspan_in = pend_rspan_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         tcgp_pkg::ST_SCAN: begin
            // latch the column, clipped extents and the column mask to mark
            pl_col_in   = fit_col;
            pl_rend_in  = rend;
            pl_cend_in  = cend;
            pl_ovf_in   = row_clip_ff || (rsum > 7'(tcgp_pkg::MAX_ROWS)) || (csum > 7'(NC));
            mask_in     = tcgp_pkg::ones_from(fit_col) & ~tcgp_pkg::ones_from(cend);
            mark_row_in = pl_row_ff;
         end
         tcgp_pkg::ST_MWRITE: begin
            occ_we                  = 1'b1;
            row_vld_in[mark_row_ff] = 1'b1;
            mark_row_in             = mark_row_ff + 1'b1;
         end
         tcgp_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               res_kind_in  = tcgp_pkg::RES_CELL;
               res_row_in   = {1'b0, pl_row_ff};
               res_col_in   = pl_col_ff;
               res_rspan_in = pl_rspan_ff;
               res_cspan_in = pl_cspan_ff;
               res_hdr_in   = in_hdr_ff;
               res_ovf_in   = pl_ovf_ff;
               if (pl_rend_ff > rows_used_ff) rows_used_in = pl_rend_ff;
               if (pl_cend_ff > cols_used_ff) cols_used_in = pl_cend_ff;
               // the oldest queued box goes with this cell, else the cell owes one
               if (q_cnt_ff != '0) begin
                  res_bvld_in = 1'b1;
                  res_box_in  = q_head_box_ff;
                  q_head_in   = q_head_ff + 1'b1;
                  q_cnt_in    = q_cnt_ff - 1'b1;
               end else begin
                  res_bvld_in = 1'b0;
                  res_box_in  = '0;
                  if (debt_ff != tcgp_pkg::DEBT_MAX) debt_in = debt_ff + 16'd1;
               end
            end
         end
         tcgp_pkg::ST_SUM: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               res_kind_in   = tcgp_pkg::RES_SUMMARY;
               res_row_in    = rows_used_ff;
               res_col_in    = cols_used_ff;
               res_rspan_in  = 5'd1;
               res_cspan_in  = 5'd1;
               res_hdr_in    = 1'b0;
               res_bvld_in   = 1'b0;
               res_box_in    = '0;
               res_ovf_in    = 1'b0;
               // drop the whole table
               cur_row_in    = '0;
               row_seen_in   = 1'b0;
               row_clip_in   = 1'b0;
               in_cell_in    = 1'b0;
               in_hdr_in     = 1'b0;
               pend_cspan_in = 5'd1;
               pend_rspan_in = 5'd1;
               rows_used_in  = '0;
               cols_used_in  = '0;
               debt_in       = '0;
               q_cnt_in      = '0;
               q_head_in     = '0;
               q_tail_in     = '0;
               row_vld_in    = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcgp_pkg::ST_IDLE;
         cur_row_ff    <= '0;
         row_seen_ff   <= 1'b0;
         row_clip_ff   <= 1'b0;
         in_cell_ff    <= 1'b0;
         in_hdr_ff     <= 1'b0;
         pend_cspan_ff <= 5'd1;
         pend_rspan_ff <= 5'd1;
         rows_used_ff  <= '0;
         cols_used_ff  <= '0;
         debt_ff       <= '0;
         q_cnt_ff      <= '0;
         q_head_ff     <= '0;
         q_tail_ff     <= '0;
         row_vld_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_row_ff    <= cur_row_in;
         row_seen_ff   <= row_seen_in;
         row_clip_ff   <= row_clip_in;
         in_cell_ff    <= in_cell_in;
         in_hdr_ff     <= in_hdr_in;
         pend_cspan_ff <= pend_cspan_in;
         pend_rspan_ff <= pend_rspan_in;
         rows_used_ff  <= rows_used_in;
         cols_used_ff  <= cols_used_in;
         debt_ff       <= debt_in;
         q_cnt_ff      <= q_cnt_in;
         q_head_ff     <= q_head_in;
         q_tail_ff     <= q_tail_in;
         row_vld_ff    <= row_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      pl_row_ff    <= pl_row_in;
      pl_cspan_ff  <= pl_cspan_in;
      pl_rspan_ff  <= pl_rspan_in;
      pl_col_ff    <= pl_col_in;
      pl_rend_ff   <= pl_rend_in;
      pl_cend_ff   <= pl_cend_in;
      pl_ovf_ff    <= pl_ovf_in;
      mask_ff      <= mask_in;
      mark_row_ff  <= mark_row_in;
      res_kind_ff  <= res_kind_in;
      res_row_ff   <= res_row_in;
      res_col_ff   <= res_col_in;
      res_rspan_ff <= res_rspan_in;
      res_cspan_ff <= res_cspan_in;
      res_hdr_ff   <= res_hdr_in;
      res_bvld_ff  <= res_bvld_in;
      res_box_ff   <= res_box_in;
      res_ovf_ff   <= res_ovf_in;
   end

   // occupancy memory: one read and one write port, registered read
   always_ff @(posedge clock) begin
      if (occ_we)
         occ_mem[mark_row_ff] <= occ_wdata;
      occ_rd_ff <= occ_mem[rd_addr];
      rd_vld_ff <= row_vld_ff[rd_addr];
   end

   // box queue storage; the head is read through a register and has long settled by emit
   always_ff @(posedge clock) begin
      if (q_we)
         box_mem[q_tail_ff] <= q_wdata;
      q_head_box_ff <= box_mem[q_head_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = res_kind_ff;
   assign rsp_grid_row      = res_row_ff;
   assign rsp_grid_col      = res_col_ff;
   assign rsp_rows_spanned  = res_rspan_ff;
   assign rsp_cols_spanned  = res_cspan_ff;
   assign rsp_header_cell   = res_hdr_ff;
   assign rsp_box_valid     = res_bvld_ff;
   assign rsp_cell_left     = res_box_ff.left;
   assign rsp_cell_top      = res_box_ff.top;
   assign rsp_cell_right    = res_box_ff.right;
   assign rsp_cell_bottom   = res_box_ff.bottom;
   assign rsp_grid_overflow = res_ovf_ff;

endmodule
`default_nettype wire

// ===== hdl/tcgp_checker.sv =====
`default_nettype none
module tcgp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_result_kind,
   input wire logic [6:0]  rsp_grid_row,
   input wire logic [4:0]  rsp_rows_spanned,
   input wire logic [4:0]  rsp_cols_spanned,
   input wire logic        rsp_box_valid,
   input wire logic [15:0] rsp_cell_left,
   input wire logic [15:0] rsp_cell_top,
   input wire logic [15:0] rsp_cell_right,
   input wire logic [15:0] rsp_cell_bottom,
   input wire logic        rsp_grid_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_grid_row))
      else $error("result word changed while stalled");

   a_summary_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == tcgp_pkg::RES_SUMMARY) |->
         (rsp_rows_spanned == 5'd1) && (rsp_cols_spanned == 5'd1) &&
         !rsp_box_valid && !rsp_grid_overflow)
      else $error("malformed summary word");

   a_no_box_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_box_valid |->
         (rsp_cell_left == '0) && (rsp_cell_top == '0) &&
         (rsp_cell_right == '0) && (rsp_cell_bottom == '0))
      else $error("coordinates set without a box");

   a_span_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == tcgp_pkg::RES_CELL) |->
         (rsp_rows_spanned != 5'd0) && (rsp_rows_spanned <= 5'(tcgp_pkg::MAX_SPAN)) &&
         (rsp_cols_spanned != 5'd0) && (rsp_cols_spanned <= 5'(tcgp_pkg::MAX_SPAN)))
      else $error("cell span out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind table_cell_grid_placement tcgp_checker u_tcgp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_grid_row      (rsp_grid_row),
   .rsp_rows_spanned  (rsp_rows_spanned),
   .rsp_cols_spanned  (rsp_cols_spanned),
   .rsp_box_valid     (rsp_box_valid),
   .rsp_cell_left     (rsp_cell_left),
   .rsp_cell_top      (rsp_cell_top),
   .rsp_cell_right    (rsp_cell_right),
   .rsp_cell_bottom   (rsp_cell_bottom),
   .rsp_grid_overflow (rsp_grid_overflow)
);
`default_nettype wire

// ===== tb/sv/table_cell_grid_placement_tb.sv =====
`default_nettype none
module table_cell_grid_placement_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [3:0]  kind;
      logic [7:0]  span;
      logic        has_box;
      logic [15:0] left, top, right, bottom;
   } token_word_type;

   typedef struct packed {
      logic        kind;
      logic [6:0]  row;
      logic [6:0]  col;
      logic [4:0]  rspan;
      logic [4:0]  cspan;
      logic        hdr;
      logic        bvalid;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
      logic        ovf;
   } placement_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_token_kind = '0;
   logic [7:0] req_span_value = '0;
   logic req_has_box = 1'b0;
   logic [15:0] req_box_left = '0, req_box_top = '0, req_box_right = '0, req_box_bottom = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_result_kind;
   logic [6:0] rsp_grid_row, rsp_grid_col;
   logic [4:0] rsp_rows_spanned, rsp_cols_spanned;
   logic rsp_header_cell, rsp_box_valid;
   logic [15:0] rsp_cell_left, rsp_cell_top, rsp_cell_right, rsp_cell_bottom;
   logic rsp_grid_overflow;

   table_cell_grid_placement dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Grid-placement shadow state
   logic [tcgp_pkg::MAX_COLS-1:0] occ [tcgp_pkg::MAX_ROWS];
   int  cur_row, rows_used, cols_used, q_count, debt;
   bit  row_seen, row_clipped, in_cell, in_hdr;
   int  pend_c, pend_r;
   logic [15:0] box_q [tcgp_pkg::QUEUE_DEPTH][4];

   token_word_type pending_words[$];
   placement_type  expected_results[$];
   bit failed = 0;

   function automatic void clear_grid();
      foreach (occ[i]) occ[i] = '0;
      cur_row = 0; rows_used = 0; cols_used = 0; q_count = 0; debt = 0;
      row_seen = 0; row_clipped = 0; in_cell = 0; in_hdr = 0;
      pend_c = 1; pend_r = 1;
   endfunction

   function automatic int span_limit(logic [7:0] v);
      if (v == 8'd0) return 1;
      if (v > tcgp_pkg::MAX_SPAN) return tcgp_pkg::MAX_SPAN;
      return int'(v);
   endfunction

   function automatic void place(int cspan, int rspan);
      placement_type p;
      int col, rend, cend;
      bit fits, ovf;
      if (!row_seen) begin
         row_seen = 1;
         cur_row = 0;
      end
      ovf = row_clipped;
      for (col = 0; col < tcgp_pkg::MAX_COLS; col++) begin
         fits = 1;
         for (int o = 0; o < cspan; o++)
            if (col + o < tcgp_pkg::MAX_COLS && occ[cur_row][col+o]) fits = 0;
         if (fits) break;
      end
      rend = cur_row + rspan;
      cend = col + cspan;
      if (rend > tcgp_pkg::MAX_ROWS) begin
         rend = tcgp_pkg::MAX_ROWS;
         ovf = 1;
      end
      if (cend > tcgp_pkg::MAX_COLS) begin
         cend = tcgp_pkg::MAX_COLS;
         ovf = 1;
      end
      for (int r = cur_row; r < rend; r++)
         for (int c = col; c < cend; c++) occ[r][c] = 1'b1;
      if (rend > rows_used) rows_used = rend;
      if (cend > cols_used) cols_used = cend;
      p = '{tcgp_pkg::RES_CELL, 7'(cur_row), 7'(col), 5'(rspan), 5'(cspan), in_hdr, 1'b0,
            16'd0, 16'd0, 16'd0, 16'd0, ovf};
      if (q_count > 0) begin
         p.bvalid = 1'b1;
         {p.left, p.top, p.right, p.bottom} = {box_q[0][0], box_q[0][1], box_q[0][2], box_q[0][3]};
         for (int i = 0; i < q_count - 1; i++) box_q[i] = box_q[i+1];
         q_count--;
      end else if (debt < 65535) debt++;
      expected_results = {expected_results, p};
   endfunction

   // Advance the shadow state by one accepted word
   function automatic void predict_word(token_word_type w);
      placement_type s;
      if (w.has_box) begin
         if (debt > 0) debt--;
         else if (q_count < tcgp_pkg::QUEUE_DEPTH) begin
            box_q[q_count] = '{w.left, w.top, w.right, w.bottom};
            q_count++;
         end
      end
      case (w.kind)
         tcgp_pkg::TOK_HDR_OPEN:   in_hdr = 1;
         tcgp_pkg::TOK_HDR_CLOSE:  in_hdr = 0;
         tcgp_pkg::TOK_ROW: begin
            if (!row_seen) begin
               row_seen = 1;
               cur_row = 0;
            end else if (cur_row + 1 < tcgp_pkg::MAX_ROWS) cur_row++;
            else row_clipped = 1;
         end
         tcgp_pkg::TOK_EMPTY_CELL: place(1, 1);
         tcgp_pkg::TOK_CELL_OPEN: begin
            in_cell = 1; pend_c = 1; pend_r = 1;
         end
         tcgp_pkg::TOK_COLSPAN:    if (in_cell) pend_c = span_limit(w.span);
         tcgp_pkg::TOK_ROWSPAN:    if (in_cell) pend_r = span_limit(w.span);
         tcgp_pkg::TOK_CELL_CLOSE: if (in_cell) begin
            place(pend_c, pend_r);
            in_cell = 0;
         end
         tcgp_pkg::TOK_END: begin
            s = '{tcgp_pkg::RES_SUMMARY, 7'(rows_used), 7'(cols_used), 5'd1, 5'd1, 1'b0,
                  1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0};
            expected_results = {expected_results, s};
            clear_grid();
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver: hold each word until accepted, then idle a random gap
   int send_gap = 0;
   always @(posedge clock) begin
      token_word_type w;
      int gap;
      if (!reset) begin
         if (req_valid && req_ready) predict_word(pending_words.pop_front());
         if (!(req_valid && !req_ready)) begin
            if (req_valid && req_ready) gap = pick_gap();
            else gap = send_gap;
            if (gap > 0) begin
               send_gap <= gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               w = pending_words[0];
               send_gap <= 0;
               req_valid <= 1'b1;
               req_token_kind <= w.kind;
               req_span_value <= w.span;
               req_has_box <= w.has_box;
               req_box_left <= w.left;
               req_box_top <= w.top;
               req_box_right <= w.right;
               req_box_bottom <= w.bottom;
            end else begin
               send_gap <= 0;
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result word with the oldest prediction
   int stall = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            placement_type a, e;
            a = {rsp_result_kind, rsp_grid_row, rsp_grid_col, rsp_rows_spanned,
                 rsp_cols_spanned, rsp_header_cell, rsp_box_valid, rsp_cell_left,
                 rsp_cell_top, rsp_cell_right, rsp_cell_bottom, rsp_grid_overflow};
            if (expected_results.size() == 0) begin
               failed = 1;
               $display("%0t: unexpected result word %p", $time, a);
            end else begin
               e = expected_results.pop_front();
               if (a !== e) begin
                  failed = 1;
                  $display("%0t: mismatch expected %p actual %p", $time, e, a);
               end
            end
         end
         if (stall > 0) begin
            stall <= stall - 1;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            stall <= pick_gap();
            rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
   end

   // Watchdog: end the run if nothing moves for too long
   int quiet = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("table_cell_grid_placement verification failed");
         $finish;
      end
   end

   function automatic token_word_type mk(logic [3:0] k, logic [7:0] s = 8'd0, bit b = 1'b0);
      token_word_type w;
      w.kind = k; w.span = s; w.has_box = b;
      w.left = 16'($urandom); w.top = 16'($urandom);
      w.right = 16'($urandom); w.bottom = 16'($urandom);
      return w;
   endfunction

   function automatic bit coin(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic logic [7:0] rand_span();
      int r = $urandom_range(0, 99);
      if (r < 60) return 8'($urandom_range(0, 3));
      if (r < 85) return 8'($urandom_range(4, 21));
      return 8'($urandom_range(0, 255));
   endfunction

   int n_items = 0;
   task automatic add(token_word_type w);
      pending_words = {pending_words, w};
      n_items++;
   endtask

   // One table: rows of cells with random spans, a sprinkle of noise
   task automatic add_table(int nrows, int ncells);
      if (coin(40)) add(mk(tcgp_pkg::TOK_HDR_OPEN, 8'd0, coin(50)));
      for (int r = 0; r < nrows; r++) begin
         add(mk(tcgp_pkg::TOK_ROW, 8'($urandom), coin(30)));
         if (r == 1 && coin(50)) add(mk(tcgp_pkg::TOK_HDR_CLOSE, 8'd0, coin(30)));
         for (int c = 0; c < ncells; c++) begin
            if (coin(25)) add(mk(tcgp_pkg::TOK_EMPTY_CELL, 8'($urandom), coin(70)));
            else begin
               add(mk(tcgp_pkg::TOK_CELL_OPEN, 8'($urandom), coin(70)));
               if (coin(40)) add(mk(tcgp_pkg::TOK_COLSPAN, rand_span(), coin(20)));
               if (coin(30)) add(mk(tcgp_pkg::TOK_ROWSPAN, rand_span(), coin(20)));
               if (coin(8)) add(mk(4'($urandom_range(8, 15)), 8'($urandom), coin(50)));
               add(mk(tcgp_pkg::TOK_CELL_CLOSE, 8'($urandom), coin(30)));
            end
         end
      end
      if (coin(10)) add(mk(tcgp_pkg::TOK_COLSPAN, rand_span(), coin(50)));
      add(mk(tcgp_pkg::TOK_END, 8'($urandom), coin(30)));
   endtask

   initial begin
      token_word_type w;
      clear_grid();
      // Directed: cell before row, spans at extremes, stray tokens, boxes
      add(mk(tcgp_pkg::TOK_COLSPAN, 8'd5, 1'b1));
      add(mk(tcgp_pkg::TOK_CELL_CLOSE));
      add(mk(tcgp_pkg::TOK_EMPTY_CELL));
      add(mk(tcgp_pkg::TOK_HDR_OPEN, 8'hFF, 1'b1));
      add(mk(tcgp_pkg::TOK_CELL_OPEN));
      add(mk(tcgp_pkg::TOK_COLSPAN, 8'd255));
      add(mk(tcgp_pkg::TOK_ROWSPAN, 8'd0));
      add(mk(tcgp_pkg::TOK_CELL_CLOSE));
      add(mk(tcgp_pkg::TOK_HDR_CLOSE));
      add(mk(tcgp_pkg::TOK_ROW, 8'd0, 1'b1));
      add(mk(tcgp_pkg::TOK_CELL_OPEN));
      add(mk(tcgp_pkg::TOK_ROWSPAN, 8'd20));
      add(mk(tcgp_pkg::TOK_COLSPAN, 8'd21));
      add(mk(tcgp_pkg::TOK_CELL_CLOSE));
      w = mk(tcgp_pkg::TOK_EMPTY_CELL, 8'd0, 1'b1);
      w.left = 16'hFFFF; w.top = 16'd0; w.right = 16'hFFFF; w.bottom = 16'd0;
      add(w);
      add(mk(tcgp_pkg::TOK_IGNORE, 8'd0, 1'b1));
      add(mk(4'd15, 8'hFF, 1'b1));
      add(mk(tcgp_pkg::TOK_END));
      // Directed: fill the row, then walk past the last grid row
      for (int i = 0; i < 4; i++) begin
         add(mk(tcgp_pkg::TOK_CELL_OPEN));
         add(mk(tcgp_pkg::TOK_COLSPAN, 8'd20));
         add(mk(tcgp_pkg::TOK_ROWSPAN, 8'd20));
         add(mk(tcgp_pkg::TOK_CELL_CLOSE));
      end
      for (int i = 0; i < 66; i++) add(mk(tcgp_pkg::TOK_ROW));
      add(mk(tcgp_pkg::TOK_EMPTY_CELL));
      add(mk(tcgp_pkg::TOK_END));
      // Box queue fill past its depth
      for (int i = 0; i < 20; i++) add(mk(tcgp_pkg::TOK_IGNORE, 8'd0, 1'b1));
      add(mk(tcgp_pkg::TOK_END));
      while (n_items < 1550) begin
         if (coin(85)) add_table($urandom_range(1, 6), $urandom_range(1, 6));
         else add(mk(4'($urandom), 8'($urandom), coin(50)));
      end
      add(mk(tcgp_pkg::TOK_END));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (100) @(posedge clock);
      if (!failed && expected_results.size() == 0)
         $display("table_cell_grid_placement verification clean");
      else
         $display("table_cell_grid_placement verification failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/tcgp_pkg.sv
hdl/table_cell_grid_placement.sv
hdl/tcgp_checker.sv
tb/sv/table_cell_grid_placement_tb.sv
